/* rtl/accel_tilt_angle_with_calibration_macros.svh */
// assertion macros for the tilt block checker
// no dependencies
`ifndef ACCEL_TILT_ANGLE_WITH_CALIBRATION_MACROS_SVH
`define ACCEL_TILT_ANGLE_WITH_CALIBRATION_MACROS_SVH
// implication checked every clock outside reset
`define TILT_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("tilt check failed");
// next-cycle implication checked outside reset
`define TILT_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("tilt check failed");
`endif

/* rtl/tilt_pkg.sv */
// shared constants and tables for the tilt block
// no dependencies
package tilt_pkg;
    localparam int SampleBitsDef  = 16;
    localparam int CordicStepsDef = 16;
    localparam int CalibW         = 10;
    localparam int CalibReset     = 200;
    localparam int PreShift       = 14;
    localparam int AngW           = 30;   // angle accumulator, 2^-16 degree
    localparam int SumW           = 27;
    localparam int PitchW         = 16;
    localparam int RollW          = 17;
    localparam int PoffW          = 15;
    localparam int RoffW          = 16;
    localparam int QuotW          = 27;

    function automatic logic signed [AngW-1:0] atan_entry(input logic [4:0] i);
        logic signed [AngW-1:0] v;
        unique case (i)
            5'd0:  v = 30'sd2949120;
            5'd1:  v = 30'sd1740967;
            5'd2:  v = 30'sd919879;
            5'd3:  v = 30'sd466945;
            5'd4:  v = 30'sd234379;
            5'd5:  v = 30'sd117304;
            5'd6:  v = 30'sd58666;
            5'd7:  v = 30'sd29335;
            5'd8:  v = 30'sd14668;
            5'd9:  v = 30'sd7334;
            5'd10: v = 30'sd3667;
            5'd11: v = 30'sd1833;
            5'd12: v = 30'sd917;
            5'd13: v = 30'sd458;
            5'd14: v = 30'sd229;
            5'd15: v = 30'sd115;
            5'd16: v = 30'sd57;
            5'd17: v = 30'sd29;
            5'd18: v = 30'sd14;
            5'd19: v = 30'sd7;
            5'd20: v = 30'sd4;
            5'd21: v = 30'sd2;
            5'd22: v = 30'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

/* rtl/tilt_if.sv */
// valid/ready channel interfaces for the tilt block
// no dependencies
interface tilt_in_if #(parameter int SAMPLE_BITS = 16);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_BITS-1:0]  accel_x;
    logic signed [SAMPLE_BITS-1:0]  accel_y;
    logic signed [SAMPLE_BITS-1:0]  accel_z;
    modport source (output valid, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface tilt_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pitch_angle;
    logic signed [16:0] roll_angle;
    modport source (output valid, pitch_angle, roll_angle, input ready);
    modport sink   (input valid, pitch_angle, roll_angle, output ready);
endinterface

/* rtl/tilt_cordic.sv */
// shared vectoring cordic, one micro-rotation per cycle, atan2 in 1/128 degree
// depends on tilt_pkg
module tilt_cordic import tilt_pkg::*; #(
    parameter int OPW   = 18,
    parameter int STEPS = CordicStepsDef
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [OPW-1:0] i_y,
    input  logic signed [OPW-1:0] i_x,
    output logic                  o_done,
    output logic signed [RollW-1:0] o_angle
);
    localparam int W  = OPW + PreShift + 3;
    localparam int NS = (STEPS > 24) ? 24 : STEPS;

    logic signed [W-1:0]    r_x, r_y, n_x, n_y;
    logic signed [AngW-1:0] r_z, n_z;
    logic [4:0]             r_i;
    logic                   r_busy, r_zero, r_done;
    logic signed [W-1:0]    xs, ys, x0, y0;
    logic signed [AngW-1:0] zr;

    always_comb begin
        x0 = W'(i_x) <<< PreShift;
        y0 = W'(i_y) <<< PreShift;
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        if (!r_y[W-1]) begin
            n_x = r_x + ys; n_y = r_y - xs; n_z = r_z + atan_entry(r_i);
        end else begin
            n_x = r_x - ys; n_y = r_y + xs; n_z = r_z - atan_entry(r_i);
        end
        zr = (r_z + AngW'(256)) >>> 9;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_i == 5'(NS-1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_zero <= (i_x == '0) && (i_y == '0);
                if (i_x[OPW-1]) begin
                    r_x <= -x0; r_y <= -y0;
                    r_z <= i_y[OPW-1] ? -AngW'(180*65536) : AngW'(180*65536);
                end else begin
                    r_x <= x0; r_y <= y0; r_z <= '0;
                end
            end else if (r_busy) begin
                r_x <= n_x; r_y <= n_y; r_z <= n_z;
                r_i <= r_i + 5'd1;
                if (r_i == 5'(NS-1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_zero ? '0 : RollW'(zr);
endmodule

/* rtl/accel_tilt_angle_with_calibration.sv */
// tilt block top level: bit-serial magnitude, shared cordic, calibration
// depends on tilt_pkg, tilt_if, tilt_cordic
//
// One sample beat in, at most one result beat out. Each sample runs the
// bit-serial squares, the digit-serial square root, two passes of the shared
// vectoring cordic (pitch, then roll) and a post step, and its result then
// moves into the output register. The first calib_count samples (0 acts as
// 1) are summed with saturation and give no result; the sample that
// finishes calibration then runs a restoring divider and a step to form both
// offsets. Later samples give pitch and roll minus the offsets. A finished
// result sits in the output register, and one new sample may be taken while
// it waits.
module accel_tilt_angle_with_calibration import tilt_pkg::*; #(
    parameter int SAMPLE_BITS  = SampleBitsDef,
    parameter int CORDIC_STEPS = CordicStepsDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CalibW-1:0] i_cfg_wdata,
    tilt_in_if.sink           i_in,
    tilt_out_if.source        o_out
);
    localparam int SB  = SAMPLE_BITS;
    localparam int SQW = 2*SB + 1;          // ax^2 + az^2
    localparam int MGW = SB + 1;            // magnitude
    localparam int OPW = SB + 2;            // cordic operand
    localparam int SCW = $clog2(SQW + 1) + 1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001, S_MUL = 8'b00000010, S_SQRT = 8'b00000100,
        S_PIT  = 8'b00001000, S_ROL = 8'b00010000, S_POST = 8'b00100000,
        S_DIV  = 8'b01000000, S_OUT = 8'b10000000
    } t_state;

    t_state r_state;
    logic [CalibW-1:0] r_calib_count, r_calib_seen;
    logic r_calibrated;
    logic signed [SumW-1:0] r_psum, r_rsum;
    logic signed [PoffW-1:0] r_poff;
    logic signed [RoffW-1:0] r_roff;
    logic signed [SB-1:0] r_ax, r_ay, r_az;
    logic [SB-1:0] r_mx, r_mz;               // magnitudes, shifted out lsb first
    logic [SQW-1:0] r_acc_x, r_acc_z;        // shift-add products
    logic [SQW-1:0] r_rem, r_root;
    logic [SCW-1:0] r_cnt;
    logic signed [RollW-1:0] r_pitch, r_roll;
    logic r_start, r_dv;
    logic [QuotW-1:0] r_pq, r_rq, r_pr, r_rr;
    logic r_pneg, r_rneg;
    logic signed [PitchW-1:0] r_opitch;
    logic signed [RollW-1:0] r_oroll;
    logic r_ovalid;

    logic signed [OPW-1:0] c_y, c_x;
    logic c_done;
    logic signed [RollW-1:0] c_ang;

    tilt_cordic #(.OPW(OPW), .STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_y(c_y), .i_x(c_x), .o_done(c_done), .o_angle(c_ang)
    );

    // operand select: pitch uses (ay, mag), roll uses (-ax, az)
    always_comb begin
        if (r_state == S_PIT) begin
            c_y = OPW'(r_ay);
            c_x = OPW'($signed({1'b0, r_root[MGW-1:0]}));
        end else begin
            c_y = -OPW'(r_ax);
            c_x = OPW'(r_az);
        end
    end

    // one sample in flight; take a new one only when idle, even if output waits
    assign i_in.ready        = (r_state == S_IDLE) && !r_dv;
    assign o_out.valid       = r_ovalid;
    assign o_out.pitch_angle = r_opitch;
    assign o_out.roll_angle  = r_oroll;

    // finished result moves into the output register when it is free
    logic out_load;
    assign out_load = (r_state == S_IDLE) && r_dv && !(r_ovalid && !o_out.ready);

    // sqrt digit trial
    logic [SQW+1:0] trial;
    logic [SQW+1:0] rem2;
    logic [SQW-1:0] sq_sum;
    assign sq_sum = r_acc_x + r_acc_z;
    assign rem2   = {r_rem, r_acc_x[SQW-1 -: 2]};
    assign trial  = {r_root, 2'b01};

    // saturating sums
    logic signed [SumW:0] ps_n, rs_n;
    logic signed [SumW-1:0] ps_sat, rs_sat;
    localparam logic signed [SumW:0] SMAX = (SumW+1)'((1 <<< (SumW-1)) - 1);
    localparam logic signed [SumW:0] SMIN = -(SumW+1)'(1 <<< (SumW-1));
    always_comb begin
        ps_n = (SumW+1)'(r_psum) + (SumW+1)'(r_pitch);
        rs_n = (SumW+1)'(r_rsum) + (SumW+1)'(c_ang);
        ps_sat = (ps_n > SMAX) ? SumW'(SMAX) : (ps_n < SMIN) ? SumW'(SMIN) : SumW'(ps_n);
        rs_sat = (rs_n > SMAX) ? SumW'(SMAX) : (rs_n < SMIN) ? SumW'(SMIN) : SumW'(rs_n);
    end

    logic [CalibW-1:0] seen_n, need;
    assign seen_n = (r_calib_seen == '1) ? r_calib_seen : r_calib_seen + 1'b1;
    assign need   = (r_calib_count == '0) ? CalibW'(1) : r_calib_count;

    // restoring divide step for both sums
    logic [QuotW:0] rdiff;
    logic [QuotW-1:0] pr_sh, rr_sh;
    assign pr_sh = {r_pr[QuotW-2:0], r_pq[QuotW-1]};
    assign rr_sh = {r_rr[QuotW-2:0], r_rq[QuotW-1]};
    assign rdiff = {1'b0, rr_sh} - {{(QuotW+1-CalibW){1'b0}}, r_calib_seen};
    logic [QuotW:0] pd;
    assign pd = {1'b0, pr_sh} - {{(QuotW+1-CalibW){1'b0}}, r_calib_seen};

    logic signed [QuotW-1:0] pq_s, rq_s;
    assign pq_s = r_pneg ? -$signed(r_pq) : $signed(r_pq);
    assign rq_s = r_rneg ? -$signed(r_rq) : $signed(r_rq);

    // cordic start pulse: after the last root digit, then after the pitch pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b0;
        end else begin
            r_start <= ((r_state == S_SQRT) && (r_cnt == SCW'(SB))) ||
                       ((r_state == S_PIT) && c_done);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_calib_count <= CalibW'(CalibReset);
            r_calib_seen  <= '0;
            r_calibrated  <= 1'b0;
            r_psum        <= '0;
            r_rsum        <= '0;
            r_poff        <= '0;
            r_roff        <= '0;
            r_dv          <= 1'b0;
            r_ovalid      <= 1'b0;
        end else begin
            if (i_cfg_we) r_calib_count <= i_cfg_wdata;
            if (out_load) r_ovalid <= 1'b1;
            else if (o_out.valid && o_out.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (out_load) begin
                        r_opitch <= PitchW'(r_pitch - RollW'(r_poff));
                        r_oroll  <= r_roll - RollW'(r_roff);
                        r_dv     <= 1'b0;
                    end else if (i_in.valid && i_in.ready) begin
                        r_ax <= i_in.accel_x; r_ay <= i_in.accel_y;
                        r_az <= i_in.accel_z;
                        r_mx <= i_in.accel_x[SB-1] ? SB'(-i_in.accel_x) : i_in.accel_x;
                        r_mz <= i_in.accel_z[SB-1] ? SB'(-i_in.accel_z) : i_in.accel_z;
                        r_acc_x <= '0; r_acc_z <= '0;
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // shift-add square, one multiplier bit per cycle
                    // multiplicand is the full-width magnitude formed from r_ax/r_az
                    if (r_mx[0]) r_acc_x <= r_acc_x + (SQW'(r_ax[SB-1] ? -SQW'(r_ax)
                                                        : SQW'(r_ax)) << r_cnt);
                    if (r_mz[0]) r_acc_z <= r_acc_z + (SQW'(r_az[SB-1] ? -SQW'(r_az)
                                                        : SQW'(r_az)) << r_cnt);
                    r_mx <= r_mx >> 1; r_mz <= r_mz >> 1;
                    if (r_cnt == SCW'(SB-1)) begin
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SQRT: begin
                    if (r_cnt == '0) begin
                        // fold the two squares into one radicand, top 2*SB bits
                        r_acc_x <= sq_sum << 1; r_acc_z <= '0;
                        r_rem <= '0; r_root <= '0;
                        r_cnt <= SCW'(1);
                    end else begin
                        // one result bit per cycle, radicand shifted two bits
                        r_acc_x <= r_acc_x << 2;
                        if (rem2 >= trial) begin
                            r_rem  <= SQW'(rem2 - trial);
                            r_root <= {r_root[SQW-2:0], 1'b1};
                        end else begin
                            r_rem  <= SQW'(rem2);
                            r_root <= {r_root[SQW-2:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == SCW'(SB)) begin
                            r_state <= S_PIT;
                        end
                    end
                end
                S_PIT: begin
                    if (c_done) begin
                        r_pitch <= c_ang;
                        r_state <= S_ROL;
                    end
                end
                S_ROL: begin
                    if (c_done) begin
                        r_roll  <= c_ang;
                        r_state <= S_POST;
                        if (!r_calibrated) begin
                            r_psum <= ps_sat; r_rsum <= rs_sat;
                            r_calib_seen <= seen_n;
                        end
                    end
                end
                S_POST: begin
                    if (r_calibrated) begin
                        r_dv <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_calib_seen >= need) begin
                        r_pneg <= r_psum[SumW-1]; r_rneg <= r_rsum[SumW-1];
                        r_pq <= r_psum[SumW-1] ? QuotW'(-r_psum) : QuotW'(r_psum);
                        r_rq <= r_rsum[SumW-1] ? QuotW'(-r_rsum) : QuotW'(r_rsum);
                        r_pr <= '0; r_rr <= '0; r_cnt <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    r_pq <= {r_pq[QuotW-2:0], !pd[QuotW]};
                    r_pr <= pd[QuotW] ? pr_sh : QuotW'(pd);
                    r_rq <= {r_rq[QuotW-2:0], !rdiff[QuotW]};
                    r_rr <= rdiff[QuotW] ? rr_sh : QuotW'(rdiff);
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == SCW'(QuotW-1)) r_state <= S_OUT;
                end
                S_OUT: begin
                    r_poff <= (pq_s > QuotW'(16383)) ? PoffW'(16383) :
                              (pq_s < -QuotW'(16384)) ? -PoffW'(16384) : PoffW'(pq_s);
                    r_roff <= (rq_s > QuotW'(32767)) ? RoffW'(32767) :
                              (rq_s < -QuotW'(32768)) ? -RoffW'(32768) : RoffW'(rq_s);
                    r_calibrated <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* rtl/tilt_checker.sv */
// port-level checker for the tilt block, bound to the top level
// depends on tilt_pkg and the macros header
`include "accel_tilt_angle_with_calibration_macros.svh"
module tilt_checker import tilt_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [PitchW-1:0] pitch,
    input logic signed [RollW-1:0]  roll
);
    // a waiting result holds its value
    `TILT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, $stable(pitch) && $stable(roll) && out_valid)
    // a beat in means no acceptance in the next cycle
    `TILT_ASSERT_NXT(a_one_in, i_clk, i_rst_n, in_valid && in_ready, !in_ready)
    // pitch lies within plus or minus 180 degrees
    `TILT_ASSERT_IMP(a_pitch_rng, i_clk, i_rst_n, out_valid, (pitch <= 16'sd23040) && (pitch >= -16'sd23040))
endmodule

bind accel_tilt_angle_with_calibration tilt_checker u_tilt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_in.valid), .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready),
    .pitch(o_out.pitch_angle), .roll(o_out.roll_angle)
);
